FILE: hdl/packet_sequence_loss_tracker_defines.svh
// ---------------------------------------------------------------------------
// Packet sequence loss tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef PACKET_SEQUENCE_LOSS_TRACKER_DEFINES_SVH
`define PACKET_SEQUENCE_LOSS_TRACKER_DEFINES_SVH

// same-cycle implication
`define PSLT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pslt assertion failed");

// next-cycle implication
`define PSLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pslt assertion failed");

`endif

FILE: hdl/pslt_pkg.sv
// ---------------------------------------------------------------------------
// Packet sequence loss tracker package
// Word types, register indexes, routes, back-end states and shared helpers.
// ---------------------------------------------------------------------------
package pslt_pkg;

	localparam int DEF_SOURCE_SYSTEMS    = 256;
	localparam int DEF_SOURCE_COMPONENTS = 256;
	localparam int DEF_COUNTER_BITS      = 32;

	localparam int          PCT_BITS    = 15;
	localparam int          NORM_LIMIT  = 61;
	localparam int          QUEUE_DEPTH = 2;
	localparam logic [14:0] FULL_SCALE  = 15'd25600;

	typedef enum logic [1:0] {
		REG_AUTOPILOT   = 2'd0,
		REG_GIMBAL      = 2'd1,
		REG_STATUS_MASK = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ROUTE_AUTOPILOT = 2'd0,
		ROUTE_GIMBAL    = 2'd1,
		ROUTE_NONE      = 2'd2
	} route_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_NORM,
		ST_DIV,
		ST_SMOOTH
	} back_state_t;

	typedef struct packed {
		logic [7:0] source_system;
		logic [7:0] source_component;
		logic [7:0] sequence_req;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  reporting_system;
		logic [7:0]  lost_now;
		logic [1:0]  route;
		logic        status_valid;
		logic [31:0] received_total;
		logic [31:0] lost_total;
		logic [32:0] sent_total;
		logic [14:0] loss_percent;
	} out_word_t;

	// classified header, as held in the queue between front and back
	typedef struct packed {
		logic [7:0] system;
		logic [7:0] sys_idx;
		logic [7:0] comp_idx;
		logic [7:0] sequence_num;
		route_t     route;
	} qent_t;

	// v mod m for a constant m in 1..256, by binary restoring reduction
	function automatic logic [7:0] mod_const(input logic [7:0] v, input int unsigned m);
		logic [15:0] acc;
		logic [15:0] step;
		acc = {8'd0, v};
		for (int k = 7; k >= 0; k--) begin
			step = 16'(m) << k;
			if (acc >= step) begin
				acc = acc - step;
			end
		end
		return acc[7:0];
	endfunction

endpackage

FILE: hdl/packet_sequence_loss_tracker.sv
// ---------------------------------------------------------------------------
// Packet sequence loss tracker
// Tracks per system/component sequence gaps, loss totals and a smoothed
// loss percentage from already parsed message headers.
// ---------------------------------------------------------------------------
//
//  channel  direction  word                     handshake
//  -------  ---------  -----------------------  ----------------------
//  in       sink       in_data (in_word_t)      in_valid / in_ready
//  out      source     out_data (out_word_t)    out_valid / out_ready
//  cfg      sink       cfg_index, cfg_data      cfg_valid / cfg_ready
//
//  Each word passes pop and table read, update, normalize (repeated while a total
//  has a bit above 60, so only for counters of 62 bits or more), a serial divider
//  that builds the 15 quotient bits by shift and repeated subtract, then smoothing.
//  After reset the seen table is cleared one entry a cycle, SOURCE_SYSTEMS *
//  SOURCE_COMPONENTS entries (65536 by default), with in_ready low; cfg is open.
//  A two-word queue lets the input run ahead; a stalled result holds smoothing.
//
module packet_sequence_loss_tracker import pslt_pkg::*; #(
	parameter int SOURCE_SYSTEMS    = DEF_SOURCE_SYSTEMS,
	parameter int SOURCE_COMPONENTS = DEF_SOURCE_COMPONENTS,
	parameter int COUNTER_BITS      = DEF_COUNTER_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_word_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_word_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] autopilot_q;
	logic [7:0] gimbal_q;
	logic [7:0] status_mask_q;

	logic  clear_busy;
	logic  push_valid, push_ready;
	qent_t push_data;
	logic  pop_valid, pop_ready;
	qent_t pop_data;

	// config writes always land at once; unknown indexes drop
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			autopilot_q   <= 8'd1;
			gimbal_q      <= 8'd154;
			status_mask_q <= 8'd31;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_AUTOPILOT:   autopilot_q   <= cfg_data;
				REG_GIMBAL:      gimbal_q      <= cfg_data;
				REG_STATUS_MASK: status_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify the incoming word: table indexes and route
	pslt_front #(
		.SOURCE_SYSTEMS   (SOURCE_SYSTEMS),
		.SOURCE_COMPONENTS(SOURCE_COMPONENTS)
	) u_front (
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.in_data            (in_data),
		.autopilot_component(autopilot_q),
		.gimbal_component   (gimbal_q),
		.clear_busy         (clear_busy),
		.push_valid         (push_valid),
		.push_ready         (push_ready),
		.push_data          (push_data)
	);

	// decouple front and back
	pslt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// tables, totals, divider and output register
	pslt_back #(
		.SOURCE_SYSTEMS   (SOURCE_SYSTEMS),
		.SOURCE_COMPONENTS(SOURCE_COMPONENTS),
		.COUNTER_BITS     (COUNTER_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.status_mask(status_mask_q),
		.clear_busy (clear_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

FILE: hdl/pslt_front.sv
// ---------------------------------------------------------------------------
// Packet sequence loss tracker front end
// Accepts header words, reduces ids to table indexes and picks the route.
// ---------------------------------------------------------------------------
module pslt_front import pslt_pkg::*; #(
	parameter int SOURCE_SYSTEMS    = DEF_SOURCE_SYSTEMS,
	parameter int SOURCE_COMPONENTS = DEF_SOURCE_COMPONENTS
) (
	input  logic       in_valid,
	output logic       in_ready,
	input  in_word_t   in_data,
	input  logic [7:0] autopilot_component,
	input  logic [7:0] gimbal_component,
	input  logic       clear_busy,
	output logic       push_valid,
	input  logic       push_ready,
	output qent_t      push_data
);

	route_t route;

	// autopilot wins when both registers match
	always_comb begin
		if (in_data.source_component == autopilot_component) begin
			route = ROUTE_AUTOPILOT;
		end else if (in_data.source_component == gimbal_component) begin
			route = ROUTE_GIMBAL;
		end else begin
			route = ROUTE_NONE;
		end
	end

	always_comb begin
		push_data.system       = in_data.source_system;
		push_data.sys_idx      = mod_const(in_data.source_system, SOURCE_SYSTEMS);
		push_data.comp_idx     = mod_const(in_data.source_component, SOURCE_COMPONENTS);
		push_data.sequence_num = in_data.sequence_req;
		push_data.route        = route;
	end

	// hold off input while the seen table is being cleared
	assign push_valid = in_valid & ~clear_busy;
	assign in_ready   = push_ready & ~clear_busy;

endmodule

FILE: hdl/pslt_queue.sv
// ---------------------------------------------------------------------------
// Packet sequence loss tracker queue
// Short FIFO of classified headers between the front and back ends.
// ---------------------------------------------------------------------------
module pslt_queue import pslt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  qent_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output qent_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	qent_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/pslt_back.sv
// ---------------------------------------------------------------------------
// Packet sequence loss tracker back end
// Pair tables, saturating totals, serial loss divider and output register.
// ---------------------------------------------------------------------------
`include "packet_sequence_loss_tracker_defines.svh"

module pslt_back import pslt_pkg::*; #(
	parameter int SOURCE_SYSTEMS    = DEF_SOURCE_SYSTEMS,
	parameter int SOURCE_COMPONENTS = DEF_SOURCE_COMPONENTS,
	parameter int COUNTER_BITS      = DEF_COUNTER_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  qent_t      pop_data,
	input  logic [7:0] status_mask,
	output logic       clear_busy,
	output logic       out_valid,
	input  logic       out_ready,
	output out_word_t  out_data
);

	localparam int PAIRS  = SOURCE_SYSTEMS * SOURCE_COMPONENTS;
	localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int CB     = COUNTER_BITS;
	localparam int CNT_W  = $clog2(PCT_BITS + 1);

	back_state_t state_q, state_nx;

	// pair tables
	logic             seen_mem [PAIRS];
	logic [7:0]       last_mem [PAIRS];
	logic             seen_rd_q;
	logic [7:0]       last_rd_q;
	logic [PAIR_W-1:0] rd_addr;
	logic [PAIR_W-1:0] pair_q;
	logic [PAIR_W-1:0] clr_q;
	logic             seen_we;
	logic [PAIR_W-1:0] seen_wa;
	logic             seen_wd;
	logic             last_we;

	qent_t            item_q;
	logic [7:0]       lost_now_q;

	// totals and normalized copies for the divider
	logic [CB-1:0]    rcv_q, lst_q;
	logic [CB-1:0]    rcv_n_q, lst_n_q;
	logic [CB-1:0]    rcv_nx, lst_nx;
	logic [CB:0]      lsum;
	logic [7:0]       lost_now;
	logic             need_norm;

	// divider
	logic [CB-1:0]    div_a_q;
	logic [CB:0]      div_b_q;
	logic [CB+2:0]    div_r_q;
	logic [14:0]      div_q_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic             div_ge;
	logic             div_done;
	logic [CB+2:0]    div_r_shift;

	logic [14:0]      run_q;
	logic [15:0]      smooth_sum;
	logic [14:0]      smooth;
	logic             out_load;
	logic             status;
	out_word_t        out_q;
	logic             out_valid_q;

	assign rd_addr = PAIR_W'(32'(pop_data.sys_idx) * SOURCE_COMPONENTS + 32'(pop_data.comp_idx));

	assign need_norm  = ((rcv_n_q | lst_n_q) >> NORM_LIMIT) != '0;
	assign div_ge     = (div_r_q >= (CB+3)'(div_b_q));
	assign div_done   = !div_ge && (div_cnt_q == '0);
	assign div_r_shift = (div_r_q << 1) +
		((FULL_SCALE[div_cnt_q - 1'b1]) ? (CB+3)'(div_a_q) : '0);

	assign lost_now = seen_rd_q ? (item_q.sequence_num - last_rd_q - 8'd1) : 8'd0;
	assign rcv_nx   = (rcv_q == '1) ? rcv_q : rcv_q + 1'b1;
	assign lsum     = {1'b0, lst_q} + (CB+1)'(lost_now);
	assign lst_nx   = lsum[CB] ? '1 : lsum[CB-1:0];

	assign smooth_sum = {1'b0, div_q_q} + {1'b0, run_q};
	assign smooth     = (smooth_sum[15:1] > FULL_SCALE) ? FULL_SCALE : smooth_sum[15:1];
	assign status     = ((rcv_q & CB'(status_mask)) == '0);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == PAIR_W'(PAIRS - 1)) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (pop_valid) begin
					state_nx = ST_UPDATE;
				end
			end
			ST_UPDATE: state_nx = ST_NORM;
			ST_NORM: begin
				if (!need_norm) begin
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_nx = ST_SMOOTH;
				end
			end
			ST_SMOOTH: begin
				if (!out_valid_q || out_ready) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_CLEAR;
		endcase
	end

	// control outputs
	always_comb begin
		pop_ready  = 1'b0;
		clear_busy = 1'b0;
		seen_we    = 1'b0;
		seen_wa    = pair_q;
		seen_wd    = 1'b1;
		last_we    = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clear_busy = 1'b1;
				seen_we    = 1'b1;
				seen_wa    = clr_q;
				seen_wd    = 1'b0;
			end
			ST_IDLE:   pop_ready = 1'b1;
			ST_UPDATE: begin
				seen_we = 1'b1;
				last_we = 1'b1;
			end
			ST_SMOOTH: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (seen_we) begin
			seen_mem[seen_wa] <= seen_wd;
		end
		if (last_we) begin
			last_mem[pair_q] <= item_q.sequence_num;
		end
		if (pop_ready && pop_valid) begin
			seen_rd_q <= seen_mem[rd_addr];
			last_rd_q <= last_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			rcv_q       <= '0;
			lst_q       <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_UPDATE) begin
				rcv_q <= rcv_nx;
				lst_q <= lst_nx;
			end
			if (out_load) begin
				run_q <= smooth;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath without reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= pop_data;
				pair_q <= rd_addr;
			end
			ST_UPDATE: begin
				lost_now_q <= lost_now;
				rcv_n_q    <= rcv_nx;
				lst_n_q    <= lst_nx;
			end
			ST_NORM: begin
				if (need_norm) begin
					rcv_n_q <= rcv_n_q >> 1;
					lst_n_q <= lst_n_q >> 1;
				end else begin
					div_a_q   <= lst_n_q;
					div_b_q   <= {1'b0, rcv_n_q} + {1'b0, lst_n_q};
					div_r_q   <= '0;
					div_q_q   <= '0;
					div_cnt_q <= CNT_W'(PCT_BITS);
				end
			end
			ST_DIV: begin
				// reduce while the remainder covers the divisor, then bring in the next bit
				if (div_ge) begin
					div_r_q <= div_r_q - (CB+3)'(div_b_q);
					div_q_q <= div_q_q + 1'b1;
				end else if (div_cnt_q != '0) begin
					div_r_q   <= div_r_shift;
					div_q_q   <= div_q_q << 1;
					div_cnt_q <= div_cnt_q - 1'b1;
				end
			end
			ST_SMOOTH: begin
				if (out_load) begin
					out_q.reporting_system <= status ? item_q.system : 8'd0;
					out_q.lost_now         <= lost_now_q;
					out_q.route            <= item_q.route;
					out_q.status_valid     <= status;
					out_q.received_total   <= 32'(rcv_q);
					out_q.lost_total       <= 32'(lst_q);
					out_q.sent_total       <= 33'({1'b0, rcv_q} + {1'b0, lst_q});
					out_q.loss_percent     <= smooth;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PSLT_ASSERT_NOW(a_no_pop_in_clear, state_q == ST_CLEAR, !(pop_ready && pop_valid))
	`PSLT_ASSERT_NOW(a_quot_in_range, state_q == ST_DIV && div_done, div_q_q <= FULL_SCALE)
	`PSLT_ASSERT_NEXT(a_rcv_monotonic, 1'b1, rcv_q >= $past(rcv_q))
	`PSLT_ASSERT_NEXT(a_load_shows, out_load, out_valid)
	`PSLT_ASSERT_NOW(a_run_clamped, 1'b1, run_q <= FULL_SCALE)

endmodule
